// ===== src/csd_pkg.sv =====
// Shared types and constants for the corner set stability detector.
`timescale 1ns / 1ps
`default_nettype none
package csd_pkg;

  localparam int HISTORY_FRAMES  = 10;
  localparam int MAX_CORNERS     = 64;
  localparam int SLOT_W          = $clog2(HISTORY_FRAMES);
  localparam int FRAME_CNT_W     = $clog2(HISTORY_FRAMES + 1);
  localparam int IDX_W           = $clog2(MAX_CORNERS);
  localparam int CNT_W           = $clog2(MAX_CORNERS + 1);
  localparam int RAM_DEPTH       = HISTORY_FRAMES << IDX_W;
  localparam int ADDR_W          = SLOT_W + IDX_W;
  localparam int X_W             = 15;
  localparam int Y_W             = 14;
  localparam int ENTRY_W         = 2 * X_W + 2 * Y_W;
  localparam int IN_DATA_W       = ((ENTRY_W + 7) / 8) * 8;
  localparam int SUM_W           = 26;
  localparam int OUT_DATA_W      = ((SUM_W + 7) / 8) * 8;
  localparam int DIST_W          = 17;
  localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] THRESHOLD_RESET = SUM_W'(16000);

  typedef struct packed {
    logic [Y_W-1:0] ry;
    logic [X_W-1:0] rx;
    logic [Y_W-1:0] ly;
    logic [X_W-1:0] lx;
  } corner_t;

  typedef struct packed {
    logic data_v;
    logic clear;
  } acc_ctl_t;

endpackage
`default_nettype wire

// ===== src/csd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module csd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/csd_dist_acc.sv =====
// Shared distance unit: absolute coordinate differences and saturating accumulator.
`timescale 1ns / 1ps
`default_nettype none
module csd_dist_acc
  import csd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire acc_ctl_t   ctl,
  input  wire corner_t    cur,
  input  wire corner_t    stored,
  output logic            busy,
  output logic [SUM_W-1:0] acc
);

  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              dist_v_r;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [SUM_W:0]    sum_wide;

  function automatic logic [X_W-1:0] absdiff(input logic [X_W-1:0] a, input logic [X_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    dist_nxt = DIST_W'(absdiff(cur.lx, stored.lx))
             + DIST_W'(absdiff(X_W'(cur.ly), X_W'(stored.ly)))
             + DIST_W'(absdiff(cur.rx, stored.rx))
             + DIST_W'(absdiff(X_W'(cur.ry), X_W'(stored.ry)));
    sum_wide = {1'b0, acc_r} + (SUM_W + 1)'(dist_r);
    acc_nxt  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      dist_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      dist_v_r <= ctl.data_v;
      if (dist_v_r) begin
        acc_r <= acc_nxt;
      end
    end
    dist_r <= dist_nxt;
  end

  assign busy = dist_v_r;
  assign acc  = acc_r;

endmodule
`default_nettype wire

// ===== src/corner_set_stability_detector_unit.sv =====
// Top level: frame history sequencer with history RAM and shared distance unit.
// Each corner passes IDLE and FINISH while filling; once full, corners within MAX_CORNERS
// also pass SCAN and DRAIN, one RAM read per stored frame into the shared distance unit.
// A frame result is registered in FINISH of its last corner, once the output is free.
// Corners are taken only in IDLE, one at a time; a last corner waits while a result is held.
// Reset (rst_n low, synchronous): history counts empty, threshold 16000, RAM not cleared.
`timescale 1ns / 1ps
`default_nettype none
module corner_set_stability_detector_unit
  import csd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [SUM_W-1:0]      cfg_wr_data,  // stable_threshold
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,     // left_x, left_y, right_x, right_y
  input  wire logic                  in_tlast,     // last_corner
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,    // error_sum
  output logic [1:0]                 out_tuser     // stable, compared
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                 state_r;
  corner_t                cur_r;
  corner_t                stored;
  logic                   last_r;
  logic [SUM_W-1:0]       thr_r;
  logic [FRAME_CNT_W-1:0] frames_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [SLOT_W-1:0]      slot_inc;
  logic [SLOT_W-1:0]      scan_r;
  logic [CNT_W-1:0]       idx_r;
  logic                   rd_v_r;
  logic                   out_valid_r;
  logic                   stable_r;
  logic                   compared_r;
  logic [SUM_W-1:0]       sum_r;
  logic                   in_acc;
  logic                   full;
  logic                   idx_ok;
  logic                   rd_issue;
  logic                   out_free;
  logic                   out_load;
  logic                   unit_busy;
  logic [SUM_W-1:0]       acc;
  logic [ENTRY_W-1:0]     rd_data;
  acc_ctl_t               ctl;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (frames_r >= FRAME_CNT_W'(HISTORY_FRAMES));
  assign idx_ok    = (idx_r < CNT_W'(MAX_CORNERS));
  assign rd_issue  = (state_r == ST_SCAN) && (scan_r != slot_r);
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == ST_FINISH) && last_r && out_free;
  assign slot_inc  = (slot_r == SLOT_W'(HISTORY_FRAMES - 1)) ? '0 : slot_r + 1'b1;
  assign stored    = corner_t'(rd_data);

  assign ctl.data_v = rd_v_r;
  assign ctl.clear  = out_load;

  csd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (in_acc && idx_ok),
    .wr_addr ({slot_r, idx_r[IDX_W-1:0]}),
    .wr_data (in_tdata[ENTRY_W-1:0]),
    .rd_en   (rd_issue),
    .rd_addr ({scan_r, idx_r[IDX_W-1:0]}),
    .rd_data (rd_data)
  );

  csd_dist_acc u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cur    (cur_r),
    .stored (stored),
    .busy   (unit_busy),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THRESHOLD_RESET;
      frames_r    <= '0;
      slot_r      <= '0;
      scan_r      <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      rd_v_r <= rd_issue;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cur_r  <= corner_t'(in_tdata[ENTRY_W-1:0]);
            last_r <= in_tlast;
            scan_r <= '0;
            state_r <= (full && idx_ok) ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (scan_r == SLOT_W'(HISTORY_FRAMES - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v_r && !unit_busy) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!last_r) begin
            if (idx_ok) begin
              idx_r <= idx_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end else if (out_free) begin
            idx_r       <= '0;
            if (full) begin
              stable_r   <= (acc < thr_r);
              compared_r <= 1'b1;
              sum_r      <= acc;
              if (acc < thr_r) begin
                frames_r <= '0;
                slot_r   <= '0;
              end else begin
                slot_r <= slot_inc;
              end
            end else begin
              stable_r   <= 1'b0;
              compared_r <= 1'b0;
              sum_r      <= '0;
              frames_r   <= frames_r + 1'b1;
              slot_r     <= slot_inc;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(sum_r);
  assign out_tuser  = {compared_r, stable_r};

  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r <= FRAME_CNT_W'(HISTORY_FRAMES))
    else $error("frame count beyond history depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(HISTORY_FRAMES))
    else $error("write slot out of range");

  a_stable_compared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && stable_r |-> compared_r)
    else $error("stable result without comparison");

  a_fill_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !compared_r |-> sum_r == '0)
    else $error("nonzero error sum while filling");

  a_no_read_own_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rd_issue |-> scan_r != slot_r && full)
    else $error("history read while not full or on own slot");

endmodule
`default_nettype wire

// ===== test/corner_set_stability_detector_unit_tb.sv =====
// Self-checking testbench for the corner set stability detector, with its own frame predictor.
`timescale 1ns / 1ps
module corner_set_stability_detector_unit_tb
  import csd_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int FRAME_MAX   = MAX_CORNERS + 4;
  localparam int X_MAX       = 20479;
  localparam int Y_MAX       = 15359;
  localparam int SETTLE      = HISTORY_FRAMES + 6;

  typedef struct {
    logic             stable;
    logic             compared;
    logic [SUM_W-1:0] error_sum;
  } frame_verdict_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [SUM_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  corner_set_stability_detector_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // frame history predictor state
  corner_t          hist_mem [HISTORY_FRAMES][MAX_CORNERS];
  int               slot_depth [HISTORY_FRAMES];
  int               frames_held   = 0;
  int               ring_slot     = 0;
  int               corner_pos    = 0;
  logic [SUM_W-1:0] frame_err     = '0;
  logic [SUM_W-1:0] threshold_now = THRESHOLD_RESET;
  frame_verdict_t   verdict_q [$];

  corner_t          frame_buf [FRAME_MAX];
  corner_t          scene [FRAME_MAX];
  int               scene_len      = 0;
  int               items_sent     = 0;
  int               mismatch_count = 0;
  int               cycle_count    = 0;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  frame_verdict_t   want;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < HISTORY_FRAMES; s++) slot_depth[s] = 0;
  end

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int pair_dist(corner_t a, corner_t b);
    return abs_diff(int'(a.lx), int'(b.lx)) + abs_diff(int'(a.ly), int'(b.ly)) +
           abs_diff(int'(a.rx), int'(b.rx)) + abs_diff(int'(a.ry), int'(b.ry));
  endfunction

  function automatic logic [SUM_W-1:0] add_corner(logic [SUM_W-1:0] acc, corner_t c,
                                                  int idx, int own);
    int unsigned total;
    total = 32'(acc);
    for (int s = 0; s < HISTORY_FRAMES; s++) begin
      if (s != own) begin
        total = total + pair_dist(hist_mem[s][idx], c);
        if (total > SUM_MAX) total = 32'(SUM_MAX);
      end
    end
    return total[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] preview_error(int n);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < n && i < MAX_CORNERS; i++)
      acc = add_corner(acc, frame_buf[i], i, ring_slot);
    return acc;
  endfunction

  function automatic void predict_corner(corner_t c, bit is_last);
    bit             hist_full;
    int             slot;
    frame_verdict_t v;
    hist_full = frames_held >= HISTORY_FRAMES;
    slot = ring_slot;
    if (corner_pos < MAX_CORNERS) begin
      if (hist_full) frame_err = add_corner(frame_err, c, corner_pos, slot);
      hist_mem[slot][corner_pos] = c;
      if (slot_depth[slot] <= corner_pos) slot_depth[slot] = corner_pos + 1;
      corner_pos++;
    end
    if (is_last) begin
      v.stable = 1'b0;
      v.compared = 1'b0;
      v.error_sum = '0;
      if (hist_full) begin
        v.stable = frame_err < threshold_now;
        v.compared = 1'b1;
        v.error_sum = frame_err;
        if (v.stable) begin
          frames_held = 0;
          ring_slot = 0;
        end else begin
          ring_slot = (slot + 1) % HISTORY_FRAMES;
        end
      end else begin
        frames_held++;
        ring_slot = (slot + 1) % HISTORY_FRAMES;
      end
      verdict_q = {verdict_q, v};
      frame_err = '0;
      corner_pos = 0;
    end
  endfunction

  // longest frame whose corners all have history written in every compared slot
  function automatic int max_frame_len();
    int m;
    m = FRAME_MAX;
    if (frames_held < HISTORY_FRAMES) return m;
    for (int s = 0; s < HISTORY_FRAMES; s++)
      if (s != ring_slot && slot_depth[s] < MAX_CORNERS && slot_depth[s] < m)
        m = slot_depth[s];
    return m;
  endfunction

  function automatic int pick_coord(int top);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(0, top);
  endfunction

  function automatic corner_t random_corner();
    corner_t c;
    c.lx = X_W'(pick_coord(X_MAX));
    c.ly = Y_W'(pick_coord(Y_MAX));
    c.rx = X_W'(pick_coord(X_MAX));
    c.ry = Y_W'(pick_coord(Y_MAX));
    return c;
  endfunction

  function automatic int nudge(int v, int top);
    int j;
    int r;
    j = $urandom_range(0, 6);
    r = v + j - 3;
    if (r < 0) r = 0;
    if (r > top) r = top;
    return r;
  endfunction

  function automatic corner_t jittered(corner_t b);
    corner_t c;
    c.lx = X_W'(nudge(int'(b.lx), X_MAX));
    c.ly = Y_W'(nudge(int'(b.ly), Y_MAX));
    c.rx = X_W'(nudge(int'(b.rx), X_MAX));
    c.ry = Y_W'(nudge(int'(b.ry), Y_MAX));
    return c;
  endfunction

  function automatic void new_scene();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) scene_len = $urandom_range(1, 16);
    else if (r < 95) scene_len = $urandom_range(17, MAX_CORNERS);
    else scene_len = $urandom_range(MAX_CORNERS + 1, FRAME_MAX);
    for (int i = 0; i < FRAME_MAX; i++) scene[i] = random_corner();
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, exp_val);
  endtask

  task automatic send_corner(corner_t c, bit is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(c);
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_corner(c, is_last);
    items_sent++;
  endtask

  task automatic send_frame(int n);
    int lim;
    lim = max_frame_len();
    if (n > lim) n = lim;
    for (int i = 0; i < n; i++) send_corner(frame_buf[i], i == n - 1);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_threshold(logic [SUM_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold_now = value;
  endtask

  task automatic test_history_fill();
    corner_t lo;
    corner_t hi;
    lo = '0;
    hi.lx = X_W'(X_MAX);
    hi.ly = Y_W'(Y_MAX);
    hi.rx = X_W'(X_MAX);
    hi.ry = Y_W'(Y_MAX);
    for (int k = 0; k < HISTORY_FRAMES; k++) begin
      frame_buf[0] = (k % 2) ? hi : lo;
      frame_buf[1] = (k % 2) ? lo : hi;
      send_frame(2);
    end
  endtask

  task automatic test_full_compare();
    frame_buf[0] = '0;
    frame_buf[1].lx = X_W'(X_MAX);
    frame_buf[1].ly = Y_W'(Y_MAX);
    frame_buf[1].rx = X_W'(X_MAX);
    frame_buf[1].ry = Y_W'(Y_MAX);
    send_frame(2);
    frame_buf[0] = frame_buf[1];
    send_frame(1);
  endtask

  task automatic test_threshold_boundary();
    frame_buf[0] = random_corner();
    set_threshold(preview_error(1));
    send_frame(1);
    frame_buf[0] = random_corner();
    set_threshold(SUM_W'(preview_error(1) + 1));
    send_frame(1);
  endtask

  task automatic test_excess_corners();
    set_threshold('0);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    for (int k = 0; k < HISTORY_FRAMES; k++) begin
      for (int i = 0; i < FRAME_MAX; i++) frame_buf[i] = random_corner();
      send_frame((k == 0) ? MAX_CORNERS + 2 : MAX_CORNERS);
    end
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < FRAME_MAX; i++) frame_buf[i] = random_corner();
      send_frame(MAX_CORNERS + 3);
    end
    set_threshold(SUM_MAX);
    for (int i = 0; i < FRAME_MAX; i++) frame_buf[i] = random_corner();
    send_frame(MAX_CORNERS + 1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // mostly jittered repeats of one scene, with noise frames and scene changes mixed in
  task automatic test_random_frames(int item_goal, int idle_pct, int stall_pct,
                                    logic [SUM_W-1:0] thr);
    int start;
    int pick;
    int n;
    set_threshold(thr);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 5 || scene_len == 0) new_scene();
      if (pick >= 90) begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) frame_buf[i] = random_corner();
      end else begin
        n = scene_len;
        for (int i = 0; i < n; i++) frame_buf[i] = jittered(scene[i]);
      end
      send_frame(n);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no frame pending, error_sum", out_tdata[SUM_W-1:0], 0);
      end else begin
        want = verdict_q.pop_front();
        if (out_tuser[0] !== want.stable)
          report_mismatch("stable", out_tuser[0], want.stable);
        if (out_tuser[1] !== want.compared)
          report_mismatch("compared", out_tuser[1], want.compared);
        if (out_tdata[SUM_W-1:0] !== want.error_sum)
          report_mismatch("error_sum", out_tdata[SUM_W-1:0], want.error_sum);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_history_fill();
    test_full_compare();
    test_threshold_boundary();
    test_excess_corners();
    test_random_frames(160, 0, 0, SUM_W'($urandom_range(300, 3000)));
    test_random_frames(160, 52, 0, SUM_W'($urandom_range(3000, 30000)));
    test_random_frames(160, 0, 52, THRESHOLD_RESET);
    test_random_frames(160, 19, 19, SUM_W'($urandom_range(0, SUM_MAX)));
    drain_results();
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== corner_set_stability_detector_unit.f =====
src/csd_pkg.sv
src/csd_ram.sv
src/csd_dist_acc.sv
src/corner_set_stability_detector_unit.sv
test/corner_set_stability_detector_unit_tb.sv
